// File: design/fbh_pkg.sv
// shared types and constants for the fixed-bin histogram
package fbh_pkg;

  localparam int NUM_BINS_DEF   = 128;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_SCALE = 2'd1;
  localparam logic [1:0] CFG_BINS  = 2'd2;

  localparam logic signed [31:0] LOWER_RST = 32'sd0;
  localparam logic [31:0]        SCALE_RST = 32'd65536;
  localparam logic [7:0]         BINS_RST  = 8'd100;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_ADD_BIN,
    OP_ADD_UNDER,
    OP_ADD_OVER,
    OP_READ,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] hit;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] lower_limit;
    logic [31:0]        bin_scale;
    logic [7:0]         n_bins;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_UPDATE
  } back_state_t;

endpackage

// File: design/fbh_front.sv
// front end: takes items, computes the bin and queues a command
module fbh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          kind,
  input  logic signed [31:0]  sample_value,
  input  logic [7:0]          read_bin,
  input  fbh_pkg::cfg_t       cfg,
  output logic                busy,
  output logic                push,
  output fbh_pkg::cmd_t       cmd
);

  logic               a_valid;
  logic               b_valid;
  logic signed [32:0] a_diff;
  logic [1:0]         a_kind;
  logic [7:0]         a_rb;
  logic               b_neg;
  logic [1:0]         b_kind;
  logic [7:0]         b_rb;
  logic [47:0]        p_hi;
  logic [47:0]        p_lo;
  logic [47:0]        mul_hi;
  logic [47:0]        mul_lo;
  logic [48:0]        q;

  assign mul_hi = {16'b0, a_diff[31:0]} * {32'b0, cfg.bin_scale[31:16]};
  assign mul_lo = {16'b0, a_diff[31:0]} * {32'b0, cfg.bin_scale[15:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_diff <= {sample_value[31], sample_value} - {cfg.lower_limit[31], cfg.lower_limit};
      a_kind <= kind;
      a_rb   <= read_bin;
    end
    if (a_valid) begin
      b_neg  <= a_diff[32];
      p_hi   <= mul_hi;
      p_lo   <= mul_lo;
      b_kind <= a_kind;
      b_rb   <= a_rb;
    end
  end

  // integer part plus truncated fraction part, as floor of diff * scale
  assign q = {1'b0, p_hi} + {17'b0, p_lo[47:16]};

  always_comb begin
    cmd.op  = fbh_pkg::OP_NONE;
    cmd.hit = 8'd0;
    unique case (b_kind)
      fbh_pkg::KIND_ADD: begin
        if (b_neg) begin
          // zero scale puts everything in the first bin
          if (cfg.bin_scale == 32'd0) begin
            cmd.op  = fbh_pkg::OP_ADD_BIN;
            cmd.hit = 8'd1;
          end else begin
            cmd.op  = fbh_pkg::OP_ADD_UNDER;
            cmd.hit = 8'd0;
          end
        end else if (q >= {41'b0, cfg.n_bins}) begin
          cmd.op  = fbh_pkg::OP_ADD_OVER;
          cmd.hit = cfg.n_bins + 8'd1;
        end else begin
          cmd.op  = fbh_pkg::OP_ADD_BIN;
          cmd.hit = q[7:0] + 8'd1;
        end
      end
      fbh_pkg::KIND_CLEAR: begin
        cmd.op = fbh_pkg::OP_CLEAR;
      end
      fbh_pkg::KIND_READ: begin
        if (b_rb != 8'd0 && b_rb <= cfg.n_bins) begin
          cmd.op  = fbh_pkg::OP_READ;
          cmd.hit = b_rb;
        end
      end
      default: begin
        cmd.op = fbh_pkg::OP_NONE;
      end
    endcase
  end

  assign push = b_valid;
  assign busy = a_valid | b_valid;

endmodule

// File: design/fbh_queue.sv
// short command queue between front and back
module fbh_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fbh_pkg::cmd_t        push_cmd,
  input  logic                 pop,
  output fbh_pkg::cmd_t        head,
  output fbh_pkg::q_status_t   status
);

  fbh_pkg::cmd_t                  entries [fbh_pkg::QUEUE_DEPTH];
  logic [fbh_pkg::QPTR_W-1:0]     wr_ptr;
  logic [fbh_pkg::QPTR_W-1:0]     rd_ptr;
  logic [fbh_pkg::QCNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + fbh_pkg::QCNT_W'(push) - fbh_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == fbh_pkg::QCNT_W'(fbh_pkg::QUEUE_DEPTH));

endmodule

// File: design/fbh_back.sv
// back end: bin memory read-modify-write, counters, clear sweep and results
module fbh_back #(
  parameter int NUM_BINS   = fbh_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = fbh_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_clear,
  input  fbh_pkg::q_status_t  qs,
  input  fbh_pkg::cmd_t       head,
  output logic                pop,
  output logic                sweeping,
  output logic                done,
  output logic [31:0]         total_count,
  output logic [31:0]         under_count,
  output logic [31:0]         over_count,
  output logic [31:0]         bin_count,
  output logic [7:0]          bin_hit
);

  localparam int AW = $clog2(NUM_BINS);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  fbh_pkg::back_state_t  state;
  fbh_pkg::back_state_t  state_next;
  logic [AW-1:0]         sweep_addr;
  logic [AW-1:0]         sweep_addr_next;
  fbh_pkg::cmd_t         cur_cmd;

  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] total_next;
  logic [COUNT_BITS-1:0] under;
  logic [COUNT_BITS-1:0] under_next;
  logic [COUNT_BITS-1:0] over;
  logic [COUNT_BITS-1:0] over_next;
  logic [COUNT_BITS-1:0] total_inc;
  logic [COUNT_BITS-1:0] under_inc;
  logic [COUNT_BITS-1:0] over_inc;
  logic [COUNT_BITS-1:0] data_inc;

  logic                  emit;
  logic [COUNT_BITS-1:0] res_bcount;
  logic [7:0]            res_hit;

  // saturating increments
  assign total_inc = (&total)   ? total   : total + 1'b1;
  assign under_inc = (&under)   ? under   : under + 1'b1;
  assign over_inc  = (&over)    ? over    : over + 1'b1;
  assign data_inc  = (&rd_data) ? rd_data : rd_data + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fbh_pkg::BK_SWEEP;
      sweep_addr <= '0;
      total      <= '0;
      under      <= '0;
      over       <= '0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      total      <= total_next;
      under      <= under_next;
      over       <= over_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd <= head;
    end
  end

  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    total_next      = total;
    under_next      = under;
    over_next       = over;
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = AW'(head.hit - 8'd1);
    wr_en           = 1'b0;
    wr_addr         = AW'(cur_cmd.hit - 8'd1);
    wr_data         = '0;
    emit            = 1'b0;
    res_bcount      = '0;
    res_hit         = 8'd0;
    unique case (state)
      fbh_pkg::BK_SWEEP: begin
        wr_en           = 1'b1;
        wr_addr         = sweep_addr;
        wr_data         = '0;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == AW'(NUM_BINS - 1)) begin
          state_next = fbh_pkg::BK_IDLE;
        end
      end
      fbh_pkg::BK_IDLE: begin
        if (qs.valid) begin
          pop = 1'b1;
          unique case (head.op) inside
            fbh_pkg::OP_ADD_BIN, fbh_pkg::OP_READ: begin
              rd_en      = 1'b1;
              state_next = fbh_pkg::BK_UPDATE;
            end
            fbh_pkg::OP_ADD_UNDER: begin
              under_next = under_inc;
              total_next = total_inc;
              emit       = 1'b1;
              res_hit    = head.hit;
            end
            fbh_pkg::OP_ADD_OVER: begin
              over_next  = over_inc;
              total_next = total_inc;
              emit       = 1'b1;
              res_hit    = head.hit;
            end
            fbh_pkg::OP_CLEAR: begin
              total_next      = '0;
              under_next      = '0;
              over_next       = '0;
              emit            = 1'b1;
              state_next      = fbh_pkg::BK_SWEEP;
              sweep_addr_next = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      fbh_pkg::BK_UPDATE: begin
        emit       = 1'b1;
        res_hit    = cur_cmd.hit;
        state_next = fbh_pkg::BK_IDLE;
        if (cur_cmd.op == fbh_pkg::OP_ADD_BIN) begin
          wr_en      = 1'b1;
          wr_data    = data_inc;
          total_next = total_inc;
          res_bcount = data_inc;
        end else begin
          res_bcount = rd_data;
        end
      end
      default: begin
        state_next = fbh_pkg::BK_SWEEP;
      end
    endcase
    // a register write reshapes the histogram
    if (cfg_clear) begin
      total_next      = '0;
      under_next      = '0;
      over_next       = '0;
      state_next      = fbh_pkg::BK_SWEEP;
      sweep_addr_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      total_count <= 32'(total_next);
      under_count <= 32'(under_next);
      over_count  <= 32'(over_next);
      bin_count   <= 32'(res_bcount);
      bin_hit     <= res_hit;
    end
  end

  assign sweeping = (state == fbh_pkg::BK_SWEEP);

endmodule

// File: design/fixed_bin_histogram_unit.sv
// top level of the fixed-bin histogram with underflow and overflow bins
//
// Commands enter on start while busy is low: kind selects add sample, clear
// or read bin, with sample_value and read_bin as operands. Each command gives
// exactly one result beat: done is high for one cycle with the counters,
// bin_count and bin_hit. The receiver cannot hold results off.
// Configuration: cfg_wr_en with cfg_index 0 lower_limit, 1 bin_scale,
// 2 bins_in_use and cfg_data; a write takes effect at once and clears the
// histogram. Write only while no command is outstanding.
// A command passes both front-end stages and the command queue; done is
// registered from the back end's idle state, or from its update state for
// adds that land in a real bin and for reads. The front end takes no new
// command until the last has left its two-stage bin calculation (subtract,
// then two 32x16 products); busy also stays high while the 2-entry queue
// is full. The back end does each bin-memory read-modify-write in its idle
// and update states. Reset, a clear command and a register write all start
// a sweep, busy held high, that zeroes the bin memory one entry per cycle.
module fixed_bin_histogram_unit #(
  parameter int NUM_BINS   = fbh_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = fbh_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] sample_value,
  input  logic [7:0]         read_bin,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [31:0]        total_count,
  output logic [31:0]        under_count,
  output logic [31:0]        over_count,
  output logic [31:0]        bin_count,
  output logic [7:0]         bin_hit
);

  fbh_pkg::cfg_t       cfg;
  fbh_pkg::cfg_t       cfg_eff;
  logic                cfg_clear;
  logic                accept;
  logic                front_busy;
  logic                front_push;
  fbh_pkg::cmd_t       front_cmd;
  fbh_pkg::cmd_t       q_head;
  fbh_pkg::q_status_t  q_stat;
  logic                q_pop;
  logic                sweeping;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_limit <= fbh_pkg::LOWER_RST;
      cfg.bin_scale   <= fbh_pkg::SCALE_RST;
      cfg.n_bins      <= fbh_pkg::BINS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fbh_pkg::CFG_LOWER: cfg.lower_limit <= cfg_data;
        fbh_pkg::CFG_SCALE: cfg.bin_scale   <= cfg_data;
        fbh_pkg::CFG_BINS:  cfg.n_bins      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_clear = cfg_wr_en && (cfg_index == fbh_pkg::CFG_LOWER ||
                                   cfg_index == fbh_pkg::CFG_SCALE ||
                                   cfg_index == fbh_pkg::CFG_BINS);

  // bins in use clamped to 1..NUM_BINS
  always_comb begin
    cfg_eff = cfg;
    if (cfg.n_bins == 8'd0) begin
      cfg_eff.n_bins = 8'd1;
    end else if (32'(cfg.n_bins) > NUM_BINS) begin
      cfg_eff.n_bins = 8'(NUM_BINS);
    end
  end

  assign busy   = front_busy | q_stat.full | sweeping;
  assign accept = start & ~busy;

  fbh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .sample_value (sample_value),
    .read_bin     (read_bin),
    .cfg          (cfg_eff),
    .busy         (front_busy),
    .push         (front_push),
    .cmd          (front_cmd)
  );

  fbh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_stat)
  );

  fbh_back #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_clear   (cfg_clear),
    .qs          (q_stat),
    .head        (q_head),
    .pop         (q_pop),
    .sweeping    (sweeping),
    .done        (done),
    .total_count (total_count),
    .under_count (under_count),
    .over_count  (over_count),
    .bin_count   (bin_count),
    .bin_hit     (bin_hit)
  );

  // front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) front_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // a register write starts the clearing sweep
  assert property (@(posedge clk) disable iff (rst) cfg_clear |=> busy)
    else $error("register write did not start clearing sweep");

  // total counts every add, so it bounds the underflow and overflow counts
  assert property (@(posedge clk) disable iff (rst)
    done && COUNT_BITS <= 32 |-> total_count >= under_count && total_count >= over_count)
    else $error("total count below underflow or overflow count");

  // underflow and no-hit results carry a zero bin count
  assert property (@(posedge clk) disable iff (rst)
    done && bin_hit == 8'd0 |-> bin_count == 32'd0)
    else $error("nonzero bin count without a bin hit");

endmodule
